/* src/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_MARK  = 2'd0,
    KIND_UNIT  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_LEAD = 3'd1,
    ERR_PAIR_2ND = 3'd2,
    ERR_TRI_2ND  = 3'd3,
    ERR_TRI_3RD  = 3'd4
  } err_t;

  // decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_PAIR2 = 4'b0010,
    PH_TRI2  = 4'b0100,
    PH_TRI3  = 4'b1000
  } phase_t;

  localparam logic [15:0] BOM_WORD  = 16'hFEFF;
  localparam int          PART_W    = 10;
  localparam int          OUT_DATA_W = 24;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    err_t       error_code;
    logic       last;
  } result_t;

  // decoder outputs for one input item
  typedef struct packed {
    result_t             res0;
    result_t             res1;
    logic [1:0]          count;
    phase_t              phase_nxt;
    logic [PART_W-1:0]   partial_nxt;
  } dec_out_t;

endpackage

/* src/utf8_to_utf16_decoder_core.sv */
// An accepted input byte is held in the input register, decoded, and written to the
// result queue, whose head drives the result stream. One input byte per cycle while the
// queue has room; the first byte after reset can yield two items (mark then the byte's own
// item). Limited by the two-entry output queue drained at one item per cycle while out_tready is high.
// Reset (rst_n low, synchronous): decoder idle, mark pending, byte_order 0,
// queue and input register empty.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// UTF-8 byte stream to UTF-16 code unit bytes, with a leading byte-order
// mark and error items for malformed sequences.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_core
  import u8u16_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,   // byte_order
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,      // [7:0] in_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,     // [7:0] first_byte, [15:8] second_byte,
                                               // [18:16] error_code, rest zero
  output logic [1:0]            out_tuser,     // [1:0] kind
  output logic                  out_tlast      // out_last
);

  logic              byte_order_r;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  phase_t            phase_r;
  logic [PART_W-1:0] partial_r;
  logic              mark_sent_r;
  result_t           q_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  logic [1:0]        count_after_pop;
  logic              pop;
  logic              s1_move;
  logic              in_accept;
  dec_out_t          dec;
  result_t           head;

  // decode of the registered byte
  u8u16_dec u_dec (
    .in_byte    (s1_byte_r),
    .phase      (phase_r),
    .partial    (partial_r),
    .mark_sent  (mark_sent_r),
    .byte_order (byte_order_r),
    .dec        (dec)
  );

  // handshake and queue space
  assign pop             = out_tvalid && out_tready;
  assign count_after_pop = count_r - {1'b0, pop};
  assign s1_move         = s1_valid_r &&
                           (({1'b0, count_after_pop} + {1'b0, dec.count}) <= 3'd2);
  assign in_tready       = !s1_valid_r || s1_move;
  assign in_accept       = in_tvalid && in_tready;
  assign count_nxt       = count_after_pop + (s1_move ? dec.count : 2'd0);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      phase_r      <= PH_IDLE;
      partial_r    <= '0;
      mark_sent_r  <= 1'b0;
      wr_ptr_r     <= 1'b0;
      rd_ptr_r     <= 1'b0;
      count_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        byte_order_r <= cfg_wr_data;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        phase_r     <= dec.phase_nxt;
        partial_r   <= dec.partial_nxt;
        mark_sent_r <= 1'b1;
        wr_ptr_r    <= wr_ptr_r ^ dec.count[0];
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // input byte register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_tdata;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (s1_move && (dec.count != 2'd0)) begin
      q_r[wr_ptr_r] <= dec.res0;
    end
    if (s1_move && (dec.count == 2'd2)) begin
      q_r[~wr_ptr_r] <= dec.res1;
    end
  end

  // output drive
  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = {5'b0, head.error_code, head.second_byte, head.first_byte};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

`ifndef ASSERT_OFF
  // queue never overfills
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("result queue count out of range");

  // mark pending flag only becomes set again through reset
  a_mark_once: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(mark_sent_r))
    else $error("mark pending again without reset");

  // error items carry zero bytes and a nonzero code
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ERROR) |->
      (out_tdata[15:0] == 16'h0000 && out_tdata[18:16] != ERR_NONE))
    else $error("malformed error item");

  // a mark is only produced by the first byte after reset
  a_mark_first: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && mark_sent_r) |-> (dec.res0.kind != KIND_MARK))
    else $error("mark produced after the first byte");
`endif

endmodule

/* src/u8u16_dec.sv */
// ----------------------------------------------------------------------------
// u8u16_dec
// Combinational decode of one UTF-8 byte against the current phase: gives
// up to two result items and the next decoder state.
// ----------------------------------------------------------------------------
module u8u16_dec
  import u8u16_pkg::*;
(
  input  logic [7:0]        in_byte,
  input  phase_t            phase,
  input  logic [PART_W-1:0] partial,
  input  logic              mark_sent,
  input  logic              byte_order,
  output dec_out_t          dec
);

  // word packed into two bytes in the selected order
  function automatic result_t make_word(kind_t k, logic [15:0] w, logic order);
    result_t r;
    r.kind        = k;
    r.first_byte  = order ? w[15:8] : w[7:0];
    r.second_byte = order ? w[7:0]  : w[15:8];
    r.error_code  = ERR_NONE;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic result_t make_err(err_t e);
    result_t r;
    r.kind        = KIND_ERROR;
    r.first_byte  = 8'h00;
    r.second_byte = 8'h00;
    r.error_code  = e;
    r.last        = 1'b0;
    return r;
  endfunction

  logic    cont;
  logic    has_res;
  result_t res_b;
  result_t res_m;

  assign cont = (in_byte[7:6] == 2'b10);

  always_comb begin
    // byte decode
    has_res         = 1'b0;
    res_b           = make_err(ERR_NONE);
    dec.phase_nxt   = phase;
    dec.partial_nxt = partial;
    case (phase)
      PH_IDLE: begin
        if (in_byte[7] == 1'b0) begin
          has_res = 1'b1;
          res_b   = make_word(KIND_UNIT, {8'h00, in_byte}, byte_order);
        end else if (in_byte[7:5] == 3'b110) begin
          dec.partial_nxt = {5'b0, in_byte[4:0]};
          dec.phase_nxt   = PH_PAIR2;
        end else if (in_byte[7:4] == 4'b1110) begin
          dec.partial_nxt = {6'b0, in_byte[3:0]};
          dec.phase_nxt   = PH_TRI2;
        end else begin
          has_res = 1'b1;
          res_b   = make_err(ERR_BAD_LEAD);
        end
      end
      PH_PAIR2: begin
        has_res         = 1'b1;
        res_b           = cont ? make_word(KIND_UNIT, {5'b0, partial[4:0], in_byte[5:0]},
                                           byte_order)
                               : make_err(ERR_PAIR_2ND);
        dec.phase_nxt   = PH_IDLE;
        dec.partial_nxt = '0;
      end
      PH_TRI2: begin
        if (cont) begin
          dec.partial_nxt = {partial[3:0], in_byte[5:0]};
          dec.phase_nxt   = PH_TRI3;
        end else begin
          has_res         = 1'b1;
          res_b           = make_err(ERR_TRI_2ND);
          dec.phase_nxt   = PH_IDLE;
          dec.partial_nxt = '0;
        end
      end
      PH_TRI3: begin
        has_res         = 1'b1;
        res_b           = cont ? make_word(KIND_UNIT, {partial, in_byte[5:0]}, byte_order)
                               : make_err(ERR_TRI_3RD);
        dec.phase_nxt   = PH_IDLE;
        dec.partial_nxt = '0;
      end
      default: begin
        dec.phase_nxt   = PH_IDLE;
        dec.partial_nxt = '0;
      end
    endcase

    // mark goes ahead of the byte's own result
    res_m = make_word(KIND_MARK, BOM_WORD, byte_order);
    if (!mark_sent) begin
      dec.res0      = res_m;
      dec.res0.last = !has_res;
      dec.res1      = res_b;
      dec.res1.last = 1'b1;
      dec.count     = has_res ? 2'd2 : 2'd1;
    end else begin
      dec.res0      = res_b;
      dec.res0.last = 1'b1;
      dec.res1      = res_b;
      dec.count     = has_res ? 2'd1 : 2'd0;
    end
  end

endmodule
